// ----- rtl/core/yuvo_pkg.sv -----
`default_nettype none

package yuvo_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int VID_REG_W  = 13;
    localparam int PIC_REG_W  = 9;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_VIDEO = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIDEO_WIDTH,
        CFG_VIDEO_HEIGHT,
        CFG_PICTURE_WIDTH,
        CFG_PICTURE_HEIGHT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PLANE_Y,
        PLANE_U,
        PLANE_V
    } t_plane;

    // control bits that ride along the pipeline with each transfer
    typedef struct packed {
        logic       valid;
        logic       is_load;
        logic       wr_en;
        logic       hit;
        logic       fend;
        t_plane     plane;
        logic [7:0] data;
    } t_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/yuvo_ctrl.sv -----
`default_nettype none

module yuvo_ctrl #(
    parameter int MAX_PICTURE_SIDE = 256,
    parameter int MAX_VIDEO_SIDE   = 4096,
    localparam int PS_W   = $clog2(MAX_PICTURE_SIDE + 1),
    localparam int C_W    = $clog2(MAX_PICTURE_SIDE),
    localparam int DEPTH  = MAX_PICTURE_SIDE * MAX_PICTURE_SIDE * 3 / 2,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int AREA_W = $clog2(MAX_PICTURE_SIDE * MAX_PICTURE_SIDE + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [yuvo_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [yuvo_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_adv,
    input  wire logic                             i_accept,
    input  wire logic                             i_cmd,
    input  wire logic [7:0]                       i_data,
    input  wire logic                             i_first,
    output yuvo_pkg::t_ctl                        o_ctl,
    output logic [C_W-1:0]                        o_row,
    output logic [C_W-1:0]                        o_col,
    output logic [PS_W-1:0]                       o_mult,
    output logic [ADDR_W-1:0]                     o_ld_addr,
    output logic [AREA_W-1:0]                     o_area,
    output logic [ADDR_W-1:0]                     o_area_v
);

    localparam int VS_W  = $clog2(MAX_VIDEO_SIDE + 1);
    localparam int CNT_W = $clog2(MAX_VIDEO_SIDE);
    localparam int SW    = ((VS_W > PS_W) ? VS_W : PS_W) + 2;
    localparam int PTR_W = $clog2(DEPTH + 1);

    function automatic logic [VS_W-1:0] eff_video(input logic [31:0] v);
        logic [31:0] t;
        t = (v > 32'(MAX_VIDEO_SIDE)) ? 32'(MAX_VIDEO_SIDE) : v;
        t[0] = 1'b0;
        if (t < 32'd2) t = 32'd2;
        return t[VS_W-1:0];
    endfunction

    function automatic logic [PS_W-1:0] eff_picture(input logic [31:0] v);
        logic [31:0] t;
        t = (v > 32'(MAX_PICTURE_SIDE)) ? 32'(MAX_PICTURE_SIDE) : v;
        t[0] = 1'b0;
        if (t < 32'd2) t = 32'd2;
        return t[PS_W-1:0];
    endfunction

    function automatic logic in_range(input logic signed [SW-1:0] v,
                                      input logic signed [SW-1:0] side);
        return (v >= 0) && (v < side);
    endfunction

    // effective sizes, clamped and made even at write time
    logic [VS_W-1:0] r_vw, r_vh;
    logic [PS_W-1:0] r_pw, r_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw <= eff_video(32'd640);
            r_vh <= eff_video(32'd480);
            r_pw <= eff_picture(32'd256);
            r_ph <= eff_picture(32'd256);
        end else if (i_cfg_we) begin
            unique case (yuvo_pkg::t_cfg_idx'(i_cfg_idx))
                yuvo_pkg::CFG_VIDEO_WIDTH: begin
                    r_vw <= eff_video(32'(i_cfg_data[yuvo_pkg::VID_REG_W-1:0]));
                end
                yuvo_pkg::CFG_VIDEO_HEIGHT: begin
                    r_vh <= eff_video(32'(i_cfg_data[yuvo_pkg::VID_REG_W-1:0]));
                end
                yuvo_pkg::CFG_PICTURE_WIDTH: begin
                    r_pw <= eff_picture(32'(i_cfg_data[yuvo_pkg::PIC_REG_W-1:0]));
                end
                yuvo_pkg::CFG_PICTURE_HEIGHT: begin
                    r_ph <= eff_picture(32'(i_cfg_data[yuvo_pkg::PIC_REG_W-1:0]));
                end
            endcase
        end
    end

    // picture luma size and start of the v plane, both registered, the v start from r_area
    logic [2*PS_W-1:0] area_full;
    logic [AREA_W-1:0] r_area;
    logic [ADDR_W-1:0] r_area_v;

    assign area_full = r_pw * r_ph;

    always_ff @(posedge i_clk) begin
        r_area   <= area_full[AREA_W-1:0];
        r_area_v <= ADDR_W'(r_area) + ADDR_W'(r_area >> 2);
    end

    assign o_area   = r_area;
    assign o_area_v = r_area_v;

    // raster counters
    logic [CNT_W-1:0]    r_x, r_y, n_x, n_y;
    yuvo_pkg::t_plane    r_plane, n_plane, plane_inc;
    logic [VS_W-1:0]     plane_w, plane_h;
    logic [VS_W:0]       x_inc, y_inc;
    logic                wrap_x, wrap_y, frame_end, is_video;

    assign is_video = (i_cmd == yuvo_pkg::CMD_VIDEO);
    assign plane_w  = (r_plane == yuvo_pkg::PLANE_Y) ? r_vw : (r_vw >> 1);
    assign plane_h  = (r_plane == yuvo_pkg::PLANE_Y) ? r_vh : (r_vh >> 1);
    assign x_inc    = (VS_W + 1)'(r_x) + 1'b1;
    assign y_inc    = (VS_W + 1)'(r_y) + 1'b1;
    assign wrap_x   = (x_inc >= {1'b0, plane_w});
    assign wrap_y   = (y_inc >= {1'b0, plane_h});
    assign frame_end = wrap_x && wrap_y && (r_plane == yuvo_pkg::PLANE_V);

    always_comb begin
        unique case (r_plane)
            yuvo_pkg::PLANE_Y: plane_inc = yuvo_pkg::PLANE_U;
            yuvo_pkg::PLANE_U: plane_inc = yuvo_pkg::PLANE_V;
            default:           plane_inc = yuvo_pkg::PLANE_Y;
        endcase
    end

    always_comb begin
        n_x     = CNT_W'(x_inc);
        n_y     = r_y;
        n_plane = r_plane;
        if (wrap_x) begin
            n_x = '0;
            n_y = CNT_W'(y_inc);
            if (wrap_y) begin
                n_y     = '0;
                n_plane = plane_inc;
            end
        end
    end

    // load pointer
    logic [PTR_W-1:0] r_ptr, ld_addr, n_ptr;
    logic             ld_wen;

    assign ld_addr = i_first ? '0 : r_ptr;
    assign ld_wen  = (ld_addr < PTR_W'(DEPTH));
    assign n_ptr   = ld_wen ? ld_addr + 1'b1 : ld_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_plane <= yuvo_pkg::PLANE_Y;
            r_ptr   <= '0;
        end else if (i_accept) begin
            if (is_video) begin
                r_x     <= n_x;
                r_y     <= n_y;
                r_plane <= n_plane;
            end else begin
                r_ptr <= n_ptr;
            end
        end
    end

    // window of the centred picture
    logic signed [SW-1:0] vw_s, vh_s, pw_s, ph_s, sx, sy;
    logic signed [SW-1:0] j_y, i_y, j_lo, j_hi, i_lo, i_hi, j_c, i_c;
    logic                 in_plane, hit_y, hit_c;

    assign vw_s = $signed(SW'(r_vw));
    assign vh_s = $signed(SW'(r_vh));
    assign pw_s = $signed(SW'(r_pw));
    assign ph_s = $signed(SW'(r_ph));
    assign sx   = (vw_s - pw_s) >>> 1;
    assign sy   = (vh_s - ph_s) >>> 1;

    assign j_y  = $signed(SW'(r_x)) - sx;
    assign i_y  = $signed(SW'(r_y)) - sy;
    // chroma covers luma pair 2c, 2c+1: prefer the later one
    assign j_lo = $signed(SW'({r_x, 1'b0})) - sx;
    assign j_hi = $signed(SW'({r_x, 1'b1})) - sx;
    assign i_lo = $signed(SW'({r_y, 1'b0})) - sy;
    assign i_hi = $signed(SW'({r_y, 1'b1})) - sy;
    assign j_c  = in_range(j_hi, pw_s) ? j_hi : j_lo;
    assign i_c  = in_range(i_hi, ph_s) ? i_hi : i_lo;

    assign in_plane = ({1'b0, r_x} < (CNT_W + 1)'(plane_w))
                   && ({1'b0, r_y} < (CNT_W + 1)'(plane_h));
    assign hit_y = in_range(j_y, pw_s) && in_range(i_y, ph_s);
    assign hit_c = (in_range(j_hi, pw_s) || in_range(j_lo, pw_s))
                && (in_range(i_hi, ph_s) || in_range(i_lo, ph_s));

    yuvo_pkg::t_ctl   n_ctl, r_ctl;
    logic [C_W-1:0]   n_row, n_col, r_row, r_col;
    logic [PS_W-1:0]  n_mult, r_mult;
    logic [ADDR_W-1:0] r_ld_addr;

    always_comb begin
        n_ctl.valid   = i_accept;
        n_ctl.is_load = !is_video;
        n_ctl.wr_en   = ld_wen;
        n_ctl.fend    = is_video && frame_end;
        n_ctl.plane   = r_plane;
        n_ctl.data    = i_data;
        if (r_plane == yuvo_pkg::PLANE_Y) begin
            n_ctl.hit = is_video && in_plane && hit_y;
            n_row     = i_y[C_W-1:0];
            n_col     = j_y[C_W-1:0];
            n_mult    = r_pw;
        end else begin
            n_ctl.hit = is_video && in_plane && hit_c;
            n_row     = i_c[C_W:1];
            n_col     = j_c[C_W:1];
            n_mult    = r_pw >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_mult    <= n_mult;
            r_ld_addr <= ld_addr[ADDR_W-1:0];
        end
    end

    assign o_ctl     = r_ctl;
    assign o_row     = r_row;
    assign o_col     = r_col;
    assign o_mult    = r_mult;
    assign o_ld_addr = r_ld_addr;

`ifndef SYNTHESIS
    a_fend_on_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid && r_ctl.fend |-> r_ctl.plane == yuvo_pkg::PLANE_V)
        else $error("frame end outside the v plane");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid && r_ctl.is_load |-> !r_ctl.hit && !r_ctl.fend)
        else $error("load transfer flagged as video");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_W'(DEPTH))
        else $error("load pointer past store end");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/yuvo_addr.sv -----
`default_nettype none

module yuvo_addr #(
    parameter int MAX_PICTURE_SIDE = 256,
    localparam int PS_W   = $clog2(MAX_PICTURE_SIDE + 1),
    localparam int C_W    = $clog2(MAX_PICTURE_SIDE),
    localparam int DEPTH  = MAX_PICTURE_SIDE * MAX_PICTURE_SIDE * 3 / 2,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int AREA_W = $clog2(MAX_PICTURE_SIDE * MAX_PICTURE_SIDE + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire yuvo_pkg::t_ctl       i_ctl,
    input  wire logic [C_W-1:0]       i_row,
    input  wire logic [C_W-1:0]       i_col,
    input  wire logic [PS_W-1:0]      i_mult,
    input  wire logic [ADDR_W-1:0]    i_ld_addr,
    input  wire logic [AREA_W-1:0]    i_area,
    input  wire logic [ADDR_W-1:0]    i_area_v,
    output yuvo_pkg::t_ctl            o_ctl,
    output logic [ADDR_W-1:0]         o_addr
);

    localparam int PROD_W = C_W + PS_W;

    logic [PROD_W-1:0] n_prod, r_prod;
    logic [C_W-1:0]    r_col;
    logic [ADDR_W-1:0] r_ld_addr, base;
    yuvo_pkg::t_ctl    r_ctl;

    assign n_prod = i_row * i_mult;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod    <= n_prod;
            r_col     <= i_col;
            r_ld_addr <= i_ld_addr;
        end
    end

    // plane base: chroma planes follow the picture luma plane
    always_comb begin
        unique case (r_ctl.plane)
            yuvo_pkg::PLANE_Y: base = '0;
            yuvo_pkg::PLANE_U: base = ADDR_W'(i_area);
            default:           base = i_area_v;
        endcase
    end

    assign o_addr = r_ctl.is_load ? r_ld_addr
                                  : base + ADDR_W'(r_prod) + ADDR_W'(r_col);
    assign o_ctl  = r_ctl;

endmodule

`default_nettype wire

// ----- rtl/core/yuvo_store.sv -----
`default_nettype none

module yuvo_store #(
    parameter int MAX_PICTURE_SIDE = 256,
    localparam int DEPTH  = MAX_PICTURE_SIDE * MAX_PICTURE_SIDE * 3 / 2,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire yuvo_pkg::t_ctl       i_ctl,
    input  wire logic [ADDR_W-1:0]    i_addr,
    output yuvo_pkg::t_ctl            o_ctl,
    output logic [7:0]                o_rdata
);

    logic [7:0]     mem [DEPTH];
    logic [7:0]     r_rdata;
    yuvo_pkg::t_ctl r_ctl;

    // one access per transfer, in arrival order, so a read always sees earlier loads
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_ctl.valid && i_ctl.is_load && i_ctl.wr_en) begin
                mem[i_addr] <= i_ctl.data;
            end
            r_rdata <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_rdata = r_rdata;

`ifndef SYNTHESIS
    a_read_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid && !i_ctl.is_load && i_ctl.hit |-> i_addr < ADDR_W'(DEPTH))
        else $error("overlay read beyond picture store");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/yuv420_centered_image_overlay.sv -----
// a video byte passes the control, address and store registers into the output register,
// where it stays while the output is held by backpressure
// throughput: one byte (load or video) per cycle unless the output holds the pipeline,
// bounded by the single picture store port: a load write or an overlay read each cycle
// reset: counters, load pointer and pipeline valids clear, sizes return to defaults;
// the picture store is not cleared and holds garbage until loaded
`default_nettype none

module yuv420_centered_image_overlay #(
    parameter int MAX_PICTURE_SIDE = 256,
    parameter int MAX_VIDEO_SIDE   = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [yuvo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [yuvo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [7:0]                      i_s_axis_tdata,  // data_byte
    input  wire logic [1:0]                      i_s_axis_tuser,  // cmd, first_byte
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [7:0]                           o_m_axis_tdata,  // pixel_byte
    output logic [0:0]                           o_m_axis_tuser,  // replaced
    output logic                                 o_m_axis_tlast   // frame_end
);

    localparam int PS_W   = $clog2(MAX_PICTURE_SIDE + 1);
    localparam int C_W    = $clog2(MAX_PICTURE_SIDE);
    localparam int DEPTH  = MAX_PICTURE_SIDE * MAX_PICTURE_SIDE * 3 / 2;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int AREA_W = $clog2(MAX_PICTURE_SIDE * MAX_PICTURE_SIDE + 1);

    logic adv, accept;

    yuvo_pkg::t_ctl    ctl1, ctl2, ctl3;
    logic [C_W-1:0]    row1, col1;
    logic [PS_W-1:0]   mult1;
    logic [ADDR_W-1:0] ld_addr1, area_v, addr2;
    logic [AREA_W-1:0] area;
    logic [7:0]        rdata3;

    // whole pipeline moves unless a result sits unclaimed in the output register
    assign adv             = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign accept          = i_s_axis_tvalid && adv;

    yuvo_ctrl #(
        .MAX_PICTURE_SIDE (MAX_PICTURE_SIDE),
        .MAX_VIDEO_SIDE   (MAX_VIDEO_SIDE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (adv),
        .i_accept   (accept),
        .i_cmd      (i_s_axis_tuser[0]),
        .i_data     (i_s_axis_tdata),
        .i_first    (i_s_axis_tuser[1]),
        .o_ctl      (ctl1),
        .o_row      (row1),
        .o_col      (col1),
        .o_mult     (mult1),
        .o_ld_addr  (ld_addr1),
        .o_area     (area),
        .o_area_v   (area_v)
    );

    yuvo_addr #(
        .MAX_PICTURE_SIDE (MAX_PICTURE_SIDE)
    ) u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_ctl     (ctl1),
        .i_row     (row1),
        .i_col     (col1),
        .i_mult    (mult1),
        .i_ld_addr (ld_addr1),
        .i_area    (area),
        .i_area_v  (area_v),
        .o_ctl     (ctl2),
        .o_addr    (addr2)
    );

    yuvo_store #(
        .MAX_PICTURE_SIDE (MAX_PICTURE_SIDE)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (ctl2),
        .i_addr  (addr2),
        .o_ctl   (ctl3),
        .o_rdata (rdata3)
    );

    logic       r_out_valid, r_replaced, r_last;
    logic [7:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= ctl3.valid && !ctl3.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pixel    <= ctl3.hit ? rdata3 : ctl3.data;
            r_replaced <= ctl3.hit;
            r_last     <= ctl3.fend;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_pixel;
    assign o_m_axis_tuser[0] = r_replaced;
    assign o_m_axis_tlast    = r_last;

`ifndef SYNTHESIS
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && ctl3.valid && ctl3.is_load |=> !o_m_axis_tvalid)
        else $error("load transfer produced a result");

    a_video_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && ctl3.valid && !ctl3.is_load |=> o_m_axis_tvalid)
        else $error("video transfer lost at output");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int PIC_SIDE_MAX = 256;
    localparam int VID_SIDE_MAX = 4096;
    localparam int STORE_DEPTH  = PIC_SIDE_MAX * PIC_SIDE_MAX * 3 / 2;
    localparam int RANDOM_ITEMS = 250;
    localparam int IDLE_PCT     = 21;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;

    typedef logic [yuvo_pkg::CFG_DATA_W-1:0] t_cfg_word;

    typedef struct {
        logic [7:0] pixel;
        logic       hit;
        logic       fend;
    } t_video_out;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_we   = 1'b0;
    logic [yuvo_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
    t_cfg_word                      cfg_data = '0;

    logic       s_valid = 1'b0;
    logic [7:0] s_data  = '0;
    logic [1:0] s_user  = '0;
    logic       s_ready;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data;
    logic [0:0] m_user;
    logic       m_last;

    // overlay model state
    logic [7:0]       pic_mem [STORE_DEPTH];
    bit               pic_written [STORE_DEPTH];
    int unsigned      load_ptr  = 0;
    yuvo_pkg::t_plane plane_now = yuvo_pkg::PLANE_Y;
    int               col_now   = 0;
    int               row_now   = 0;
    logic [12:0]      vid_w_reg = 13'd640;
    logic [12:0]      vid_h_reg = 13'd480;
    logic [8:0]       pic_w_reg = 9'd256;
    logic [8:0]       pic_h_reg = 9'd256;

    t_video_out expected_bytes [$];
    logic       frame_done  = 1'b0;
    int         items_sent  = 0;
    int         errors      = 0;
    bit         steady_src  = 1'b0;
    bit         steady_sink = 1'b0;
    logic       hold_req    = 1'b0;

    always #10 clk = ~clk;

    yuv420_centered_image_overlay i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    function automatic int usable_side(input int raw, input int hi);
        int v;
        v = (raw > hi) ? hi : raw;
        v = v & ~1;
        return (v < 2) ? 2 : v;
    endfunction

    // offset of the last luma coordinate of the pair that lands in the window, or -1
    function automatic int last_covered(input int c, input int org, input int side);
        int hi_off;
        int lo_off;
        hi_off = 2 * c + 1 - org;
        lo_off = 2 * c - org;
        if (hi_off >= 0 && hi_off < side) return hi_off;
        if (lo_off >= 0 && lo_off < side) return lo_off;
        return -1;
    endfunction

    function automatic int picture_bytes();
        int pw;
        int ph;
        pw = usable_side(pic_w_reg, PIC_SIDE_MAX);
        ph = usable_side(pic_h_reg, PIC_SIDE_MAX);
        return pw * ph * 3 / 2;
    endfunction

    function automatic int frame_bytes();
        int vw;
        int vh;
        vw = usable_side(vid_w_reg, VID_SIDE_MAX);
        vh = usable_side(vid_h_reg, VID_SIDE_MAX);
        return vw * vh * 3 / 2;
    endfunction

    // true once every byte of the current picture has been loaded at least once
    function automatic bit picture_ready();
        int n;
        n = picture_bytes();
        for (int a = 0; a < n; a++) begin
            if (!pic_written[a]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void overlay_byte(input logic cmd, input logic [7:0] data,
                                         input logic first);
        int vw, vh, pw, ph, sx, sy, pl_w, pl_h, i, j;
        int unsigned base;
        t_video_out r;
        if (cmd == yuvo_pkg::CMD_LOAD) begin
            if (first) load_ptr = 0;
            if (load_ptr < STORE_DEPTH) begin
                pic_mem[load_ptr]     = data;
                pic_written[load_ptr] = 1'b1;
                load_ptr++;
            end
            return;
        end
        vw = usable_side(vid_w_reg, VID_SIDE_MAX);
        vh = usable_side(vid_h_reg, VID_SIDE_MAX);
        pw = usable_side(pic_w_reg, PIC_SIDE_MAX);
        ph = usable_side(pic_h_reg, PIC_SIDE_MAX);
        sx = (vw - pw) / 2;
        sy = (vh - ph) / 2;
        pl_w = (plane_now == yuvo_pkg::PLANE_Y) ? vw : vw / 2;
        pl_h = (plane_now == yuvo_pkg::PLANE_Y) ? vh : vh / 2;
        r.pixel = data;
        r.hit   = 1'b0;
        r.fend  = 1'b0;
        if (col_now < pl_w && row_now < pl_h) begin
            if (plane_now == yuvo_pkg::PLANE_Y) begin
                j = col_now - sx;
                i = row_now - sy;
                if (j >= 0 && j < pw && i >= 0 && i < ph) begin
                    r.pixel = pic_mem[i * pw + j];
                    r.hit   = 1'b1;
                end
            end else begin
                j = last_covered(col_now, sx, pw);
                i = last_covered(row_now, sy, ph);
                if (j >= 0 && i >= 0) begin
                    base = pw * ph;
                    if (plane_now == yuvo_pkg::PLANE_V) base += pw * ph / 4;
                    r.pixel = pic_mem[base + (i / 2) * (pw / 2) + j / 2];
                    r.hit   = 1'b1;
                end
            end
        end
        // counters past a shrunken plane wrap like a plane end
        col_now++;
        if (col_now >= pl_w) begin
            col_now = 0;
            row_now++;
            if (row_now >= pl_h) begin
                row_now = 0;
                case (plane_now)
                    yuvo_pkg::PLANE_Y: plane_now = yuvo_pkg::PLANE_U;
                    yuvo_pkg::PLANE_U: plane_now = yuvo_pkg::PLANE_V;
                    default: begin
                        plane_now = yuvo_pkg::PLANE_Y;
                        r.fend    = 1'b1;
                    end
                endcase
            end
        end
        frame_done = r.fend;
        expected_bytes.push_back(r);
    endfunction

    task automatic push_byte(input logic cmd, input logic [7:0] data, input logic first);
        while (!steady_src && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= data;
        s_user  <= {first, cmd};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        overlay_byte(cmd, data, first);
        items_sent++;
    endtask

    task automatic load_picture(input int n);
        for (int k = 0; k < n; k++) begin
            push_byte(yuvo_pkg::CMD_LOAD, 8'($urandom_range(255)), k == 0);
        end
    endtask

    // video reads must only hit loaded entries
    task automatic ensure_picture();
        if (!picture_ready()) load_picture(picture_bytes());
    endtask

    task automatic send_video(input int n);
        repeat (n) push_byte(yuvo_pkg::CMD_VIDEO, 8'($urandom_range(255)),
                             1'($urandom_range(1)));
    endtask

    task automatic send_frames(input int n);
        repeat (n) begin
            frame_done = 1'b0;
            do send_video(1); while (!frame_done);
        end
    endtask

    // loads give no output, so allow for loads still in the pipeline
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input yuvo_pkg::t_cfg_idx idx, input t_cfg_word val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            yuvo_pkg::CFG_VIDEO_WIDTH:   vid_w_reg = val;
            yuvo_pkg::CFG_VIDEO_HEIGHT:  vid_h_reg = val;
            yuvo_pkg::CFG_PICTURE_WIDTH: pic_w_reg = val[yuvo_pkg::PIC_REG_W-1:0];
            default:                     pic_h_reg = val[yuvo_pkg::PIC_REG_W-1:0];
        endcase
    endtask

    task automatic set_sizes(input t_cfg_word vw, input t_cfg_word vh,
                             input t_cfg_word pw, input t_cfg_word ph);
        wait_drained();
        write_reg(yuvo_pkg::CFG_VIDEO_WIDTH, vw);
        write_reg(yuvo_pkg::CFG_VIDEO_HEIGHT, vh);
        write_reg(yuvo_pkg::CFG_PICTURE_WIDTH, pw);
        write_reg(yuvo_pkg::CFG_PICTURE_HEIGHT, ph);
        cfg_we <= 1'b0;
    endtask

    function automatic void check_byte();
        t_video_out e;
        if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected output byte %h replaced %b last %b",
                     $time, m_data, m_user[0], m_last);
            errors++;
            return;
        end
        e = expected_bytes.pop_front();
        if ({e.pixel, e.hit, e.fend} !== {m_data, m_user[0], m_last}) begin
            $display("%0t: mismatch expected byte %h replaced %b last %b, got %h %b %b",
                     $time, e.pixel, e.hit, e.fend, m_data, m_user[0], m_last);
            errors++;
        end
    endfunction

    task automatic test_directed();
        logic [7:0] pic_bytes [6] = '{8'h00, 8'hff, 8'h5a, 8'ha5, 8'h01, 8'h80};
        set_sizes(13'd4, 13'd4, 13'd2, 13'd2);
        foreach (pic_bytes[k]) push_byte(yuvo_pkg::CMD_LOAD, pic_bytes[k], k == 0);
        // restart at address zero
        push_byte(yuvo_pkg::CMD_LOAD, 8'h3c, 1'b1);
        for (int k = 0; k < 24; k++) begin
            push_byte(yuvo_pkg::CMD_VIDEO, k[0] ? 8'hff : 8'h00, k[1]);
        end
    endtask

    task automatic test_size_extremes();
        // tiny values round up to the smallest frame, the picture width clamps
        // to the widest picture, so the window is clipped on the horizontal axis
        set_sizes(13'h1, 13'h0, 13'h1ff, 13'h1);
        load_picture(picture_bytes());
        send_frames(2);
    endtask

    task automatic test_backpressure();
        set_sizes(13'd8, 13'd6, 13'd4, 13'd4);
        load_picture(picture_bytes());
        hold_req   <= 1'b1;
        steady_src  = 1'b1;
        send_frames(2);
        steady_src  = 1'b0;
    endtask

    task automatic test_steady_stream();
        set_sizes(13'd10, 13'd8, 13'd4, 13'd4);
        steady_src  = 1'b1;
        steady_sink = 1'b1;
        load_picture(picture_bytes());
        send_frames(1);
        steady_src  = 1'b0;
        steady_sink = 1'b0;
    endtask

    task automatic test_random();
        int start;
        int pick;
        t_cfg_word vw, vh, pw, ph;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            vw = ($urandom_range(9) == 0) ? t_cfg_word'($urandom_range(8191))
                                          : t_cfg_word'($urandom_range(20));
            vh = ($urandom_range(9) == 0) ? t_cfg_word'($urandom_range(8191))
                                          : t_cfg_word'($urandom_range(20));
            pw = t_cfg_word'($urandom_range(12));
            ph = t_cfg_word'($urandom_range(12));
            set_sizes(vw, vh, pw, ph);
            pick = $urandom_range(9);
            if (pick < 4) begin
                load_picture(picture_bytes());
            end else if (pick < 6) begin
                // stray loads, restart flag at random
                repeat ($urandom_range(1, 8))
                    push_byte(yuvo_pkg::CMD_LOAD, 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
            ensure_picture();
            if (frame_bytes() <= 200 && $urandom_range(3) != 0)
                send_frames(1);
            else
                send_video($urandom_range(1, 60));
        end
    endtask

    initial begin : sink_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (m_valid && m_ready) check_byte();
            if (!rst_n) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left  = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= steady_sink || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #30_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_size_extremes();
        test_backpressure();
        test_steady_stream();
        test_random();
        wait_drained();
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
